FILE: hdl/q2e_pkg.sv
// Shared types, constants and arithmetic helpers of the quaternion to Euler angle converter.
package q2e_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int FRAC_BITS     = ANGLE_BITS - 3;
   localparam int NUM_STAGES    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

   localparam int Z_W        = ANGLE_BITS + 1;  // angle accumulator, holds pi plus the atan sum
   localparam int XY_W       = 38;              // rotated vector, gain and sign flip included
   localparam int SUM_W      = 36;              // 2*(a*b + c*d) and 1 - 2*(...)
   localparam int PROD_W     = 32;
   localparam int REM_W      = 57;              // 2^56 - s^2 and the root in progress
   localparam int SQRT_STEPS = 29;              // one result bit per cell
   localparam int STG_W      = 5;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic signed [15:0] PI_Q13      = 16'sd25736;
   localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

   localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) <<< 28;
   localparam logic [REM_W-1:0]        ONE_Q56 = REM_W'(1) << 56;

   localparam logic [31:0] ATAN_Q30 [24] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
      32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
      32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
      32'd1023,      32'd511,       32'd255,       32'd127
   };

   localparam int Q30_SH = 30 - FRAC_BITS;
   localparam int SH_DN  = (FRAC_BITS > 13) ? FRAC_BITS - 13 : 0;
   localparam int SH_UP  = (FRAC_BITS < 13) ? 13 - FRAC_BITS : 0;
   localparam int SH_RND = (SH_DN > 0) ? SH_DN - 1 : 0;
   localparam int RND    = (SH_DN > 0) ? (1 << SH_RND) : 0;
   localparam int R_W    = Z_W + SH_UP + 1;

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [14:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic               pitch_clamped;
   } rsp_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] wx;
      logic signed [PROD_W-1:0] yz;
      logic signed [PROD_W-1:0] xx;
      logic signed [PROD_W-1:0] yy;
      logic signed [PROD_W-1:0] wy;
      logic signed [PROD_W-1:0] zx;
      logic signed [PROD_W-1:0] wz;
      logic signed [PROD_W-1:0] xy;
      logic signed [PROD_W-1:0] zz;
   } prod_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sr;
      logic signed [SUM_W-1:0] cr;
      logic signed [SUM_W-1:0] sp;
      logic signed [SUM_W-1:0] sy;
      logic signed [SUM_W-1:0] cy;
      logic                    clamp;
      logic                    neg;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] res;
   } sqrt_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   zero;
      logic                   clamp;
      logic                   neg;
   } cordic_type;

   // Round a Q.30 constant half up to the accumulator's fraction bits.
   function automatic logic signed [Z_W-1:0] q30_to_frac(input logic [31:0] t);
      logic [32:0] s;
      s = {1'b0, t} + (33'd1 << (Q30_SH - 1));
      return Z_W'(s >> Q30_SH);
   endfunction

   function automatic logic signed [Z_W-1:0] atan_frac(input logic [STG_W-1:0] idx);
      return q30_to_frac(ATAN_Q30[idx]);
   endfunction

   // Round the accumulator half up to Q3.13 and saturate to +/- lim.
   function automatic logic signed [15:0] to_q13(input logic signed [Z_W-1:0] z,
                                                 input logic signed [15:0] lim);
      logic signed [R_W-1:0] r;
      logic signed [R_W-1:0] l;
      r = R_W'(z);
      r = (r + $signed(R_W'(RND))) >>> SH_DN;
      r = r <<< SH_UP;
      l = R_W'(lim);
      if (r > l) begin
         r = l;
      end else if (r < -l) begin
         r = -l;
      end
      return r[15:0];
   endfunction

   // Fold a vector with negative x into the right half plane.
   function automatic cordic_type prerot(input logic signed [XY_W-1:0] x,
                                         input logic signed [XY_W-1:0] y);
      cordic_type p;
      p.x     = x;
      p.y     = y;
      p.z     = '0;
      p.zero  = (x == 0) && (y == 0);
      p.clamp = 1'b0;
      p.neg   = 1'b0;
      if (x < 0) begin
         p.z = (y >= 0) ? q30_to_frac(PI_Q30) : -q30_to_frac(PI_Q30);
         p.x = -x;
         p.y = -y;
      end
      return p;
   endfunction

endpackage

FILE: hdl/q2e_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one result bit.
module q2e_sqrt_cell import q2e_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [STG_W-1:0] bit_pos,
   input  sqrt_type         up_data,
   output sqrt_type         dn_data
);

   sqrt_type         data_ff, data_in;
   logic [REM_W-1:0] bit_val;
   logic [REM_W-1:0] trial;

   always_comb begin
      bit_val = REM_W'(1) << {bit_pos, 1'b0};
      trial   = up_data.res + bit_val;
      data_in = up_data;
      if (up_data.rem >= trial) begin
         data_in.rem = up_data.rem - trial;
         data_in.res = (up_data.res >> 1) + bit_val;
      end else begin
         data_in.res = up_data.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign dn_data = data_ff;

endmodule

FILE: hdl/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its registered output.
module q2e_cordic_cell import q2e_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [STG_W-1:0] stage_idx,
   input  cordic_type       up_data,
   output cordic_type       dn_data
);

   cordic_type             data_ff, data_in;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic signed [Z_W-1:0]  ang;

   always_comb begin
      dx      = up_data.y >>> stage_idx;
      dy      = up_data.x >>> stage_idx;
      ang     = atan_frac(stage_idx);
      data_in = up_data;
      if (up_data.y >= 0) begin
         data_in.x = up_data.x + dx;
         data_in.y = up_data.y - dy;
         data_in.z = up_data.z + ang;
      end else begin
         data_in.x = up_data.x - dx;
         data_in.y = up_data.y + dy;
         data_in.z = up_data.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign dn_data = data_ff;

endmodule

FILE: hdl/quaternion_to_euler_angles.sv
// Top level: quaternion (Q2.14) to ZYX roll, pitch and yaw (Q3.13) pipeline.
//
// Usage
//   req_valid/req_ready/req_data carry one quaternion per transaction;
//   rsp_valid/rsp_ready/rsp_data return roll, pitch, yaw and the pitch clamp
//   flag, one result transaction per request, in request order.
//   The row holds 50 registers (multiply, sum, square, 29 square-root cells,
//   fold, 16 CORDIC cells, output register); the first one loads at the
//   accepting edge and the output register drives rsp_valid.
//   Throughput: one transaction per cycle; every stage is a register in a
//   row of cells, so a new quaternion enters each cycle the row advances.
//   Pitch takes asin(s) as atan2(s, sqrt(1 - s^2)); the square-root row sets
//   most of the latency, and roll and yaw wait beside it in a delay line.
//   Reset: synchronous; clears all stage valid bits and rsp_valid. Data
//   registers are not reset.
//   Stall: when rsp_valid is high and rsp_ready low, the whole row holds and
//   req_ready drops; bubbles in the row are not squeezed out but shift along as it advances.
module quaternion_to_euler_angles import q2e_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int VLD_N = 3 + SQRT_STEPS + 1 + NUM_STAGES;

   logic             adv;
   logic [VLD_N-1:0] vld_ff, vld_in;

   prod_type prod_ff, prod_in;
   side_type sum_ff, sum_in;
   side_type side_ff [SQRT_STEPS+1];
   sqrt_type sq_q [SQRT_STEPS+1];
   sqrt_type sq_in;

   cordic_type pre_in [3];
   cordic_type cq [3][NUM_STAGES+1];

   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic signed [28:0] sp_small;
   logic signed [57:0] sq_prod;

   // Advance the whole row unless a finished result waits with rsp_ready low.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[VLD_N-2:0], req_valid};

   // Products of the components.
   always_comb begin
      prod_in.wx = req_data.quat_w * req_data.quat_x;
      prod_in.yz = req_data.quat_y * req_data.quat_z;
      prod_in.xx = req_data.quat_x * req_data.quat_x;
      prod_in.yy = req_data.quat_y * req_data.quat_y;
      prod_in.wy = req_data.quat_w * req_data.quat_y;
      prod_in.zx = req_data.quat_z * req_data.quat_x;
      prod_in.wz = req_data.quat_w * req_data.quat_z;
      prod_in.xy = req_data.quat_x * req_data.quat_y;
      prod_in.zz = req_data.quat_z * req_data.quat_z;
   end

   // Sine and cosine terms, and the pitch clamp test on exact Q.28 values.
   always_comb begin
      sum_in.sr = (SUM_W'(prod_ff.wx) + SUM_W'(prod_ff.yz)) <<< 1;
      sum_in.cr = ONE_Q28 - ((SUM_W'(prod_ff.xx) + SUM_W'(prod_ff.yy)) <<< 1);
      sum_in.sp = (SUM_W'(prod_ff.wy) - SUM_W'(prod_ff.zx)) <<< 1;
      sum_in.sy = (SUM_W'(prod_ff.wz) + SUM_W'(prod_ff.xy)) <<< 1;
      sum_in.cy = ONE_Q28 - ((SUM_W'(prod_ff.yy) + SUM_W'(prod_ff.zz)) <<< 1);
      sum_in.clamp = (sum_in.sp >= ONE_Q28) || (sum_in.sp <= -ONE_Q28);
      sum_in.neg   = sum_in.sp[SUM_W-1];
   end

   // Radicand 1 - s^2 in Q.56; a clamped pitch feeds a harmless zero.
   always_comb begin
      sp_small  = sum_ff.clamp ? '0 : $signed(sum_ff.sp[28:0]);
      sq_prod   = sp_small * sp_small;
      sq_in.rem = ONE_Q56 - sq_prod[REM_W-1:0];
      sq_in.res = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff    <= prod_in;
         sum_ff     <= sum_in;
         sq_q[0]    <= sq_in;
         side_ff[0] <= sum_ff;
         for (int i = 1; i <= SQRT_STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Square root row, most significant result bit first.
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock   (clock),
         .en      (adv),
         .bit_pos (STG_W'(SQRT_STEPS - 1 - j)),
         .up_data (sq_q[j]),
         .dn_data (sq_q[j+1])
      );
   end

   // Fold each vector into the right half plane; pitch carries its clamp.
   always_comb begin
      pre_in[0] = prerot(XY_W'(side_ff[SQRT_STEPS].cr), XY_W'(side_ff[SQRT_STEPS].sr));
      pre_in[1] = prerot(XY_W'($signed({1'b0, sq_q[SQRT_STEPS].res})),
                         XY_W'(side_ff[SQRT_STEPS].sp));
      pre_in[1].clamp = side_ff[SQRT_STEPS].clamp;
      pre_in[1].neg   = side_ff[SQRT_STEPS].neg;
      pre_in[2] = prerot(XY_W'(side_ff[SQRT_STEPS].cy), XY_W'(side_ff[SQRT_STEPS].sy));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cq[0][0] <= pre_in[0];
         cq[1][0] <= pre_in[1];
         cq[2][0] <= pre_in[2];
      end
   end

   // Three CORDIC rows: roll, pitch, yaw.
   for (genvar l = 0; l < 3; l++) begin : g_lane
      for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
         q2e_cordic_cell u_cell (
            .clock     (clock),
            .en        (adv),
            .stage_idx (STG_W'(s)),
            .up_data   (cq[l][s]),
            .dn_data   (cq[l][s+1])
         );
      end
   end

   // Round, saturate and apply the pitch clamp.
   always_comb begin
      logic signed [15:0] pitch_full;
      rsp_data_in.roll_angle = cq[0][NUM_STAGES].zero ? '0 :
                               to_q13(cq[0][NUM_STAGES].z, PI_Q13);
      rsp_data_in.yaw_angle  = cq[2][NUM_STAGES].zero ? '0 :
                               to_q13(cq[2][NUM_STAGES].z, PI_Q13);
      if (cq[1][NUM_STAGES].clamp) begin
         pitch_full = cq[1][NUM_STAGES].neg ? -HALF_PI_Q13 : HALF_PI_Q13;
      end else if (cq[1][NUM_STAGES].zero) begin
         pitch_full = '0;
      end else begin
         pitch_full = to_q13(cq[1][NUM_STAGES].z, HALF_PI_Q13);
      end
      rsp_data_in.pitch_angle   = pitch_full[14:0];
      rsp_data_in.pitch_clamped = cq[1][NUM_STAGES].clamp;
   end

   assign rsp_valid_in = adv ? vld_ff[VLD_N-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/q2e_checker.sv
// Port-level checks of the converter, bound to the top level.
module q2e_checker import q2e_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Drop intake while the output is blocked.
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output blocked");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pitch_clamped |->
         (rsp_data.pitch_angle == 15'sd12868) || (rsp_data.pitch_angle == -15'sd12868))
      else $error("clamped pitch not at half pi");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.roll_angle <= 16'sd25736) && (rsp_data.roll_angle >= -16'sd25736)
                 && (rsp_data.yaw_angle <= 16'sd25736) && (rsp_data.yaw_angle >= -16'sd25736))
      else $error("angle out of range");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);
